// ===== design/imuafp_pkg.sv =====
// Shared constants and interface types of the IMU angle frame parser.
`default_nettype none
package imuafp_pkg;

   localparam int FRAME_LEN = 11;
   localparam int SUM_LEN = 10;
   localparam logic [7:0] FRAME_HEADER = 8'h55;
   localparam logic [7:0] FRAME_TYPE_ANGLE = 8'h53;
   localparam logic [15:0] DEFAULT_SAMPLES = 16'd10;
   localparam logic signed [15:0] YAW_SCALE = 16'sd18000;
   localparam int YAW_SHIFT = 15;
   localparam int DIV_STEPS = 32;

   typedef struct packed {
      logic               start;
      logic signed [31:0] dividend;
      logic [15:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// ===== design/imuafp_div.sv =====
// Iterative signed-by-unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module imuafp_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire imuafp_pkg::div_req_type   div_req,
   output imuafp_pkg::div_rsp_type        div_rsp
);

   localparam int CountWidth = $clog2(imuafp_pkg::DIV_STEPS);

   logic                  busy_ff;
   logic                  fix_ff;
   logic [CountWidth-1:0] count_ff;
   logic [15:0]           rem_ff;
   logic [31:0]           quo_ff;
   logic [15:0]           divisor_ff;
   logic                  neg_ff;
   logic                  done_ff;
   logic signed [31:0]    result_ff;

   logic [16:0] shifted_in;
   logic        fits_in;

   assign shifted_in = {rem_ff, quo_ff[31]};
   assign fits_in = shifted_in >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            fix_ff <= 1'b0;
            count_ff <= '0;
            rem_ff <= '0;
            divisor_ff <= div_req.divisor;
            neg_ff <= div_req.dividend[31];
            quo_ff <= div_req.dividend[31] ? 32'(-div_req.dividend) : div_req.dividend;
         end else if (busy_ff) begin
            // Remainder stays below the divisor, so its low 16 bits suffice.
            rem_ff <= fits_in ? 16'(shifted_in - {1'b0, divisor_ff}) : shifted_in[15:0];
            quo_ff <= {quo_ff[30:0], fits_in};
            count_ff <= count_ff + 1'b1;
            if (count_ff == CountWidth'(imuafp_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               fix_ff <= 1'b1;
            end
         end else if (fix_ff) begin
            fix_ff <= 1'b0;
            done_ff <= 1'b1;
            result_ff <= neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = result_ff;

endmodule
`default_nettype wire

// ===== design/imu_angle_frame_parser_core.sv =====
// Top level of the IMU angle frame parser: byte window, frame check, yaw scaling, calibration.
`default_nettype none
// Each request carries either one received serial byte or a start-calibration
// command, and produces exactly one response with the frame flags and the
// current yaw, offset and counter values. A small sequencer runs one request at
// a time and req_ready is low while it works. A command or a byte that does not
// complete an angle frame goes straight from acceptance to the output step. A
// byte that completes an angle frame walks the checksum through one 8-bit adder,
// one byte per cycle; a bad frame then goes to the output step, and a good one
// first passes the checksum, multiply, scale and calibration update steps. The
// good frame that ends a calibration run also waits for the 32-step divider. A
// new request is taken while the previous response still waits on rsp_ready;
// the sequencer only stalls at its last step if that response has not been
// taken yet.
module imu_angle_frame_parser_core #(
   parameter int BUFFER_DEPTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_mode,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic [15:0]        req_cal_samples,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_angle_valid,
   output logic                    rsp_checksum_error,
   output logic signed [15:0]      rsp_yaw_raw,
   output logic signed [16:0]      rsp_yaw_corrected,
   output logic signed [15:0]      rsp_yaw_zero_offset,
   output logic                    rsp_cal_complete,
   output logic [31:0]             rsp_good_frames,
   output logic [31:0]             rsp_bad_frames
);

   localparam int PosWidth = $clog2(BUFFER_DEPTH + 1);
   localparam int IdxWidth = $clog2(imuafp_pkg::FRAME_LEN);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_CHK,
      ST_MUL,
      ST_SCL,
      ST_CAL,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type          state_ff;
   logic [7:0]         window_ff [imuafp_pkg::FRAME_LEN];
   logic [PosWidth-1:0] pos_ff;
   logic signed [15:0] yaw_raw_ff;
   logic signed [15:0] scaled_ff;
   logic signed [15:0] offset_ff;
   logic [15:0]        left_ff;
   logic [15:0]        target_ff;
   logic signed [31:0] sum_ff;
   logic               fin_ff;
   logic [31:0]        good_ff;
   logic [31:0]        bad_ff;
   logic               good_flag_ff;
   logic               bad_flag_ff;
   logic [IdxWidth-1:0] idx_ff;
   logic [7:0]         acc_ff;
   logic signed [31:0] prod_ff;
   logic               rsp_valid_ff;

   logic [PosWidth-1:0] pos_in;
   logic signed [31:0]  rounded_in;
   logic signed [15:0]  scaled_in;
   logic signed [31:0]  sum_in;
   logic [15:0]         count_in;
   logic                frame_in;
   logic                last_sample_in;

   imuafp_pkg::div_req_type div_req;
   imuafp_pkg::div_rsp_type div_rsp;

   // The position restarts when it has reached the buffer depth; the new byte
   // then counts as the first one after the wrap.
   assign pos_in = (pos_ff >= PosWidth'(BUFFER_DEPTH)) ? PosWidth'(1) : pos_ff + 1'b1;

   // A frame is examined once eleven bytes are in since the last wrap and the
   // window, after this byte shifts in, starts with the angle frame header.
   assign frame_in = (pos_in >= PosWidth'(imuafp_pkg::FRAME_LEN))
                     && (window_ff[1] == imuafp_pkg::FRAME_HEADER)
                     && (window_ff[2] == imuafp_pkg::FRAME_TYPE_ANGLE);

   // Division by 32768 truncated toward zero: negative products get a bias of
   // 32767 before the arithmetic shift.
   assign rounded_in = prod_ff + (prod_ff[31] ? 32'sd32767 : 32'sd0);
   assign scaled_in = 16'(rounded_in >>> imuafp_pkg::YAW_SHIFT);

   assign sum_in = sum_ff + 32'(scaled_ff);
   assign count_in = (req_cal_samples == 16'd0) ? imuafp_pkg::DEFAULT_SAMPLES
                                                : req_cal_samples;
   assign last_sample_in = (left_ff == 16'd1);

   assign div_req.start = (state_ff == ST_CAL) && (left_ff != 16'd0) && !fin_ff
                          && last_sample_in;
   assign div_req.dividend = sum_in;
   assign div_req.divisor = target_ff;

   imuafp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < imuafp_pkg::FRAME_LEN; i++) begin
            window_ff[i] <= 8'h00;
         end
         pos_ff <= '0;
         yaw_raw_ff <= '0;
         scaled_ff <= '0;
         offset_ff <= '0;
         left_ff <= '0;
         target_ff <= '0;
         sum_ff <= '0;
         fin_ff <= 1'b0;
         good_ff <= '0;
         bad_ff <= '0;
         good_flag_ff <= 1'b0;
         bad_flag_ff <= 1'b0;
         idx_ff <= '0;
         acc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In the output step a taken response is replaced by the new one below.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  good_flag_ff <= 1'b0;
                  bad_flag_ff <= 1'b0;
                  if (req_mode) begin
                     // A new command restarts any calibration in progress.
                     fin_ff <= 1'b0;
                     sum_ff <= '0;
                     target_ff <= count_in;
                     left_ff <= count_in;
                     state_ff <= ST_OUT;
                  end else begin
                     for (int i = 0; i < imuafp_pkg::FRAME_LEN - 1; i++) begin
                        window_ff[i] <= window_ff[i + 1];
                     end
                     window_ff[imuafp_pkg::FRAME_LEN - 1] <= req_rx_byte;
                     pos_ff <= pos_in;
                     idx_ff <= '0;
                     acc_ff <= '0;
                     state_ff <= frame_in ? ST_SUM : ST_OUT;
                  end
               end
            end
            ST_SUM: begin
               acc_ff <= acc_ff + window_ff[idx_ff];
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == IdxWidth'(imuafp_pkg::SUM_LEN - 1)) begin
                  state_ff <= ST_CHK;
               end
            end
            ST_CHK: begin
               if (acc_ff != window_ff[imuafp_pkg::FRAME_LEN - 1]) begin
                  bad_ff <= bad_ff + 1'b1;
                  bad_flag_ff <= 1'b1;
                  state_ff <= ST_OUT;
               end else begin
                  good_ff <= good_ff + 1'b1;
                  good_flag_ff <= 1'b1;
                  yaw_raw_ff <= {window_ff[7], window_ff[6]};
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff <= yaw_raw_ff * imuafp_pkg::YAW_SCALE;
               state_ff <= ST_SCL;
            end
            ST_SCL: begin
               scaled_ff <= scaled_in;
               state_ff <= ST_CAL;
            end
            ST_CAL: begin
               if ((left_ff != 16'd0) && !fin_ff) begin
                  sum_ff <= sum_in;
                  left_ff <= left_ff - 1'b1;
                  state_ff <= last_sample_in ? ST_DIV : ST_OUT;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  offset_ff <= div_rsp.quotient[15:0];
                  fin_ff <= 1'b1;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_angle_valid <= good_flag_ff;
                  rsp_checksum_error <= bad_flag_ff;
                  rsp_yaw_raw <= yaw_raw_ff;
                  rsp_yaw_corrected <= {scaled_ff[15], scaled_ff}
                                       - {offset_ff[15], offset_ff};
                  rsp_yaw_zero_offset <= offset_ff;
                  rsp_cal_complete <= fin_ff;
                  rsp_good_frames <= good_ff;
                  rsp_bad_frames <= bad_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== design/imuafp_checker.sv =====
// Port-level checks for the IMU angle frame parser and their binding.
`default_nettype none
module imuafp_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_angle_valid,
   input wire logic               rsp_checksum_error,
   input wire logic signed [16:0] rsp_yaw_corrected,
   input wire logic [31:0]        rsp_good_frames
);

   // A held response must not change under the consumer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_good_frames)
                                  && $stable(rsp_angle_valid))
      else $error("held response changed");

   // One byte cannot both complete a good frame and fail a checksum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_angle_valid && rsp_checksum_error))
      else $error("good and bad frame flagged together");

   // The block works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // Scaled yaw and offset both lie within a half turn, so their difference
   // stays inside a full turn.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_yaw_corrected >= -17'sd35999) && (rsp_yaw_corrected <= 17'sd35999))
      else $error("corrected yaw out of range");

endmodule

bind imu_angle_frame_parser_core imuafp_checker u_imuafp_checker (.*);
`default_nettype wire
